### rtl/zero_duration_group_filter_assert.svh
// Assertion macros for the zero duration group filter.
`ifndef ZERO_DURATION_GROUP_FILTER_ASSERT_SVH
`define ZERO_DURATION_GROUP_FILTER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define ZDGF_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ZDGF_ASSERT_NXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

### rtl/zdgf_pkg.sv
// Shared constants and types for the zero duration group filter.
package zdgf_pkg;
   localparam int BufferDepth = 16;
   localparam int IdxBits     = $clog2(BufferDepth);
   localparam int CntBits     = $clog2(BufferDepth + 1);
   localparam int TickBits    = 32;
   localparam int IdBits      = 20;

   localparam logic [1:0] KindNone  = 2'd0;
   localparam logic [1:0] KindStart = 2'd1;
   localparam logic [1:0] KindEnd   = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  category;
      logic [15:0] value;
      logic [15:0] payload;
   } event_type;
endpackage

### rtl/zdgf_search.sv
// Sequential search of the started-group set for one identity.
module zdgf_search (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [zdgf_pkg::IdBits-1:0] ident,
   input  logic [zdgf_pkg::CntBits-1:0] count,
   output logic [zdgf_pkg::IdxBits-1:0] rd_index,
   input  logic [zdgf_pkg::IdBits-1:0] rd_data,
   output logic done,
   output logic found
);
   logic                         busy_ff, busy_in;
   logic [zdgf_pkg::CntBits-1:0] idx_ff, idx_in;
   logic                         found_ff, found_in;
   logic                         done_ff, done_in;

   assign rd_index = idx_ff[zdgf_pkg::IdxBits-1:0];
   assign done     = done_ff;
   assign found    = found_ff;

   // one entry compared per cycle
   always_comb begin
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      done_in  = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         found_in = 1'b0;
      end else if (busy_ff) begin
         if (idx_ff >= count || found_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (rd_data == ident) found_in = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         found_ff <= found_in;
         idx_ff   <= idx_in;
      end
   end
endmodule

### rtl/zero_duration_group_filter.sv
// Top level of the zero duration group filter.
//  channel | ports | direction
//  req     | req_valid, req_stall, req_* fields | in
//  rsp     | rsp_valid, rsp_stall, rsp_* fields | out
// A zero-delta event is searched among the started groups, then decided.
// A flush sends the buffered results in order, held while rsp_stall is high;
// after a delta flush the event step follows.
// A collapse walks the buffer newest first and moves later entries down to
// close each gap.
// Synchronous reset empties both sets and clears carried ticks and overflow;
// req_stall is high while a request is at work.
`include "zero_duration_group_filter_assert.svh"
module zero_duration_group_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_delta_ticks,
   input  logic [1:0]  req_group_kind,
   input  logic [3:0]  req_group_category,
   input  logic [15:0] req_group_value,
   input  logic [15:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_delta_ticks,
   output logic [1:0]  rsp_out_group_kind,
   output logic [3:0]  rsp_out_category,
   output logic [15:0] rsp_out_group_value,
   output logic [15:0] rsp_out_payload,
   output logic        rsp_last,
   output logic        rsp_overflow
);
   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StFlush  = 3'd1;
   localparam logic [2:0] StSearch = 3'd2;
   localparam logic [2:0] StDecide = 3'd3;
   localparam logic [2:0] StScan   = 3'd4;
   localparam logic [2:0] StShift  = 3'd5;

   localparam int DB = zdgf_pkg::BufferDepth;
   localparam int IB = zdgf_pkg::IdxBits;
   localparam int CB = zdgf_pkg::CntBits;
   localparam int TB = zdgf_pkg::TickBits;

   zdgf_pkg::event_type          pend_mem [DB];
   logic [zdgf_pkg::IdBits-1:0]  start_mem [DB];

   logic [2:0]          state_ff, state_in;
   logic [CB-1:0]       pcount_ff, pcount_in;
   logic [CB-1:0]       scount_ff, scount_in;
   logic [TB-1:0]       carry_ff, carry_in;
   logic                ovf_ff, ovf_in;
   logic [CB-1:0]       idx_ff, idx_in;
   logic                cmd_ff, cmd_in;
   zdgf_pkg::event_type ev_ff, ev_in;
   logic                rv_ff, rv_in;
   logic [TB-1:0]       delta_ff, delta_in;
   logic                found_ff, found_in;
   // resume point of the collapse walk after a removal
   logic [CB-1:0]       scan_resume_ff, scan_resume_in;

   logic                pend_we;
   logic [IB-1:0]       pend_wa;
   zdgf_pkg::event_type pend_wd;
   logic                start_we;

   logic [IB-1:0]               s_index;
   logic                        s_start, s_done, s_found;
   logic [zdgf_pkg::IdBits-1:0] ident;
   logic [TB:0]                 carry_sum;
   zdgf_pkg::event_type         cur_ev, nxt_ev;

   assign ident  = {ev_ff.category, ev_ff.value};
   assign cur_ev = pend_mem[idx_ff[IB-1:0]];
   assign nxt_ev = pend_mem[IB'(idx_ff + 1'b1)];

   zdgf_search u_search (
      .clock(clock), .reset(reset), .start(s_start), .ident(ident),
      .count(scount_ff), .rd_index(s_index), .rd_data(start_mem[s_index]),
      .done(s_done), .found(s_found));

   assign req_stall = (state_ff != StIdle);
   assign rsp_valid = rv_ff;
   assign carry_sum = {1'b0, carry_ff} + {1'b0, delta_ff};

   // response fields straight from the buffer entry under the flush pointer; delta from the carried ticks
   assign rsp_out_delta_ticks = carry_ff;
   assign rsp_out_group_kind  = cur_ev.kind;
   assign rsp_out_category    = cur_ev.category;
   assign rsp_out_group_value = cur_ev.value;
   assign rsp_out_payload     = cur_ev.payload;
   assign rsp_last            = (idx_ff + 1'b1 == pcount_ff);
   assign rsp_overflow        = ovf_ff;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      pcount_in = pcount_ff;
      scount_in = scount_ff;
      carry_in  = carry_ff;
      ovf_in    = ovf_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;
      ev_in     = ev_ff;
      rv_in     = rv_ff;
      delta_in  = delta_ff;
      found_in  = found_ff;
      pend_we   = 1'b0;
      pend_wa   = idx_ff[IB-1:0];
      pend_wd   = ev_ff;
      start_we  = 1'b0;
      s_start   = 1'b0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               delta_in = req_delta_ticks;
               ev_in    = '{req_group_kind, req_group_category,
                            req_group_value, req_payload};
               idx_in   = '0;
               if (req_cmd || req_delta_ticks != '0) begin
                  state_in = StFlush;
                  rv_in    = (pcount_ff != '0);
               end else begin
                  state_in = StSearch;
                  s_start  = 1'b1;
               end
            end
         end
         StFlush: begin
            if (!rv_ff) begin
               pcount_in = '0;
               scount_in = '0;
               if (cmd_ff) begin
                  carry_in = '0;
                  state_in = StIdle;
               end else begin
                  carry_in = carry_sum[TB] ? '1 : carry_sum[TB-1:0];
                  state_in = StSearch;
                  s_start  = 1'b1;
               end
            end else if (!rsp_stall) begin
               carry_in = '0;
               if (rsp_last) rv_in = 1'b0;
               else idx_in = idx_ff + 1'b1;
            end
         end
         StSearch: begin
            if (s_done) begin
               found_in = s_found;
               state_in = StDecide;
            end
         end
         StDecide: begin
            state_in = StIdle;
            if (ev_ff.kind == zdgf_pkg::KindEnd && found_ff) begin
               idx_in   = pcount_ff;
               state_in = StScan;
            end else if (pcount_ff >= CB'(DB)) begin
               ovf_in = 1'b1;
            end else if (ev_ff.kind == zdgf_pkg::KindStart && !found_ff
                         && scount_ff >= CB'(DB)) begin
               ovf_in = 1'b1;
            end else begin
               if (ev_ff.kind == zdgf_pkg::KindStart && !found_ff) begin
                  start_we  = 1'b1;
                  scount_in = scount_ff + 1'b1;
               end
               pend_we   = 1'b1;
               pend_wa   = pcount_ff[IB-1:0];
               pcount_in = pcount_ff + 1'b1;
            end
         end
         StScan: begin
            // newest first; idx points one above the entry under test
            if (idx_ff == '0) begin
               state_in = StIdle;
            end else begin
               idx_in = idx_ff - 1'b1;
               if ({pend_mem[IB'(idx_ff - 1'b1)].category,
                    pend_mem[IB'(idx_ff - 1'b1)].value} == ident) begin
                  found_in = (pend_mem[IB'(idx_ff - 1'b1)].kind
                              == zdgf_pkg::KindStart);
                  state_in = StShift;
               end
            end
         end
         StShift: begin
            // close the gap one entry a cycle
            if (idx_ff + 1'b1 < pcount_ff) begin
               pend_we = 1'b1;
               pend_wd = nxt_ev;
               idx_in  = idx_ff + 1'b1;
            end else begin
               pcount_in = pcount_ff - 1'b1;
               state_in  = found_ff ? StIdle : StScan;
               idx_in    = scan_resume_ff;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      scan_resume_in = scan_resume_ff;
      if (state_ff == StScan && state_in == StShift) scan_resume_in = idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= StIdle;
         pcount_ff      <= '0;
         scount_ff      <= '0;
         carry_ff       <= '0;
         ovf_ff         <= 1'b0;
         rv_ff          <= 1'b0;
         idx_ff         <= '0;
         scan_resume_ff <= '0;
      end else begin
         state_ff       <= state_in;
         pcount_ff      <= pcount_in;
         scount_ff      <= scount_in;
         carry_ff       <= carry_in;
         ovf_ff         <= ovf_in;
         rv_ff          <= rv_in;
         idx_ff         <= idx_in;
         scan_resume_ff <= scan_resume_in;
      end
      cmd_ff   <= cmd_in;
      ev_ff    <= ev_in;
      delta_ff <= delta_in;
      found_ff <= found_in;
   end

   // buffer stores
   always_ff @(posedge clock) begin
      if (pend_we) pend_mem[pend_wa] <= pend_wd;
      if (start_we) start_mem[scount_ff[IB-1:0]] <= ident;
   end

   `ZDGF_ASSERT_IMP(a_rsp_only_flush, clock, reset, rsp_valid, state_ff == StFlush)
   `ZDGF_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, pcount_ff <= CB'(DB))
   `ZDGF_ASSERT_NXT(a_ovf_sticky, clock, reset, ovf_ff, ovf_ff)
endmodule
